[sv/zobt_pkg.sv]
// ----------------------------------------------------------------------------
// zobt_pkg: Z-order box test shared types and helpers
// Widths, status codes and bit-mask helpers for the box test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package zobt_pkg;

  localparam int WORD_W    = 64;
  localparam int CFG_IDX_W = 1;
  localparam int STATUS_W  = 2;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // status codes
  localparam status_t ST_INSIDE = 2'd0;
  localparam status_t ST_NEXT   = 2'd1;
  localparam status_t ST_NONE   = 2'd2;

  // register indexes
  localparam cfg_idx_t REG_BOX_MIN = 1'b0;
  localparam cfg_idx_t REG_BOX_MAX = 1'b1;

  // word bits that belong to dimension d (word bit 63 is position 0)
  function automatic word_t dim_mask(input int dims, input int d);
    word_t m;
    int    cnt;
    m   = '0;
    cnt = 0;
    for (int p = 0; p < WORD_W; p++) begin
      if (cnt == d) m[WORD_W-1-p] = 1'b1;
      cnt = (cnt == dims - 1) ? 0 : cnt + 1;
    end
    return m;
  endfunction

  // partial prefix OR toward lower bits: doubling steps kfrom..kto with
  // base stride; stride 1 gives a whole-word prefix, stride DIMS a per-dim one
  function automatic word_t pref_or(input word_t x, input int stride,
                                    input int kfrom, input int kto);
    word_t r;
    r = x;
    for (int k = 0; k < 6; k++) begin
      if (k >= kfrom && k <= kto && (stride << k) < WORD_W)
        r = r | (r >> (stride << k));
    end
    return r;
  endfunction

  // same as pref_or, but spreading toward higher bits
  function automatic word_t pref_or_up(input word_t x, input int stride,
                                       input int kfrom, input int kto);
    word_t r;
    r = x;
    for (int k = 0; k < 6; k++) begin
      if (k >= kfrom && k <= kto && (stride << k) < WORD_W)
        r = r | (r << (stride << k));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/zobt_if.sv]
// ----------------------------------------------------------------------------
// zobt_if: channel interfaces of the Z-order box test
// Key request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface zobt_key_if;
  logic           valid;
  logic           ready;
  zobt_pkg::word_t current_key;
  modport source (output valid, output current_key, input ready);
  modport sink   (input valid, input current_key, output ready);
endinterface

interface zobt_res_if;
  logic              valid;
  logic              ready;
  zobt_pkg::status_t status;
  zobt_pkg::word_t   next_key;
  modport source (output valid, output status, output next_key, input ready);
  modport sink   (input valid, input status, input next_key, output ready);
endinterface

interface zobt_cfg_if;
  logic               valid;
  logic               ready;
  zobt_pkg::cfg_idx_t index;
  zobt_pkg::word_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/zorder_box_test_next_key.sv]
// ----------------------------------------------------------------------------
// zorder_box_test_next_key: Z-order box test with next in-box key
// Tests one interleaved key per request against the configured box and
// returns inside / next key / no next key.
// ----------------------------------------------------------------------------
// Usage:
//   key_i  : key requests (valid/ready), one current_key per request.
//   res_o  : one result per request, in order: status and next_key.
//   cfg_i  : register writes, index 0 box_min, index 1 box_max; always ready.
//            Write only while no request is in flight.
// Throughput: one request per cycle while results are taken or the output
//   stage is empty; set by the six-stage pipeline, whose per-dimension and
//   whole-word prefix scans are split into 3-step halves.
// Reset: box_min clears to zero, box_max to all ones, pipeline empties.
// Stall: when the result is not taken, the whole pipeline holds and key_i
//   ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module zorder_box_test_next_key #(
  parameter int DIMS     = 2,
  parameter int KEY_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  zobt_key_if.sink         key_i,
  zobt_res_if.source       res_o,
  zobt_cfg_if.sink         cfg_i
);

  localparam int W = zobt_pkg::WORD_W;
  localparam zobt_pkg::word_t KM = (KEY_BITS >= W) ? {W{1'b1}} :
      ~((zobt_pkg::word_t'(1) << (W - KEY_BITS)) - zobt_pkg::word_t'(1));

  // box registers
  zobt_pkg::word_t box_min_q, box_max_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '0;
      box_max_q <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        zobt_pkg::REG_BOX_MIN: box_min_q <= cfg_i.data;
        zobt_pkg::REG_BOX_MAX: box_max_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the output is full and held
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  assign en = !v6_q || res_o.ready;
  assign key_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else if (en) begin
      v1_q <= key_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // stage 1: mask, compare against corners, first half of per-dim scan
  zobt_pkg::word_t s1_c_q, s1_l_q, s1_pl_q, s1_ph_q;
  zobt_pkg::word_t s1_c_d, s1_l_d, s1_h_d;
  assign s1_c_d = key_i.current_key & KM;
  assign s1_l_d = box_min_q & KM;
  assign s1_h_d = box_max_q & KM;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_c_q  <= s1_c_d;
      s1_l_q  <= s1_l_d;
      s1_pl_q <= zobt_pkg::pref_or(s1_c_d ^ s1_l_d, DIMS, 0, 2);
      s1_ph_q <= zobt_pkg::pref_or(s1_c_d ^ s1_h_d, DIMS, 0, 2);
    end
  end

  // stage 2: first difference per dim, classify events, start exit scan
  zobt_pkg::word_t s2_seen_l, s2_seen_h, s2_first_l, s2_first_h;
  zobt_pkg::word_t s2_low_d, s2_high_d;
  zobt_pkg::word_t s2_c_q, s2_l_q, s2_low_q, s2_high_q, s2_rise_q, s2_drop_q, s2_ea_q;
  assign s2_seen_l  = zobt_pkg::pref_or(s1_pl_q, DIMS, 3, 5);
  assign s2_seen_h  = zobt_pkg::pref_or(s1_ph_q, DIMS, 3, 5);
  assign s2_first_l = s2_seen_l & ~(s2_seen_l >> DIMS);
  assign s2_first_h = s2_seen_h & ~(s2_seen_h >> DIMS);
  assign s2_low_d   = s2_first_l & ~s1_c_q;
  assign s2_high_d  = s2_first_h & s1_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_c_q    <= s1_c_q;
      s2_l_q    <= s1_l_q;
      s2_low_q  <= s2_low_d;
      s2_high_q <= s2_high_d;
      s2_rise_q <= s2_first_l & s1_c_q;
      s2_drop_q <= s2_first_h & ~s1_c_q;
      s2_ea_q   <= zobt_pkg::pref_or(s2_low_d | s2_high_d, DIMS, 0, 2);
    end
  end

  // stage 3: exit point per dim, events that happen no later than it
  zobt_pkg::word_t s3_seen_e, s3_prior_e, s3_first_e, s3_vdrop;
  zobt_pkg::word_t s3_c_q, s3_l_q, s3_rise_q, s3_low_q, s3_high_q, s3_da_q, s3_ga_q;
  zobt_pkg::word_t s3_fe_q;
  assign s3_seen_e  = zobt_pkg::pref_or(s2_ea_q, DIMS, 3, 5);
  assign s3_prior_e = s3_seen_e >> DIMS;
  assign s3_first_e = s3_seen_e & ~s3_prior_e;
  assign s3_vdrop   = s2_drop_q & ~s3_prior_e;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_c_q    <= s2_c_q;
      s3_l_q    <= s2_l_q;
      s3_rise_q <= s2_rise_q & ~s3_prior_e;
      s3_low_q  <= s3_first_e & s2_low_q;
      s3_high_q <= s3_first_e & s2_high_q;
      s3_fe_q   <= s3_first_e;
      s3_da_q   <= zobt_pkg::pref_or(s3_vdrop, DIMS, 0, 2);
      s3_ga_q   <= zobt_pkg::pref_or(s3_first_e, 1, 0, 2);
    end
  end

  // stage 4: earliest exit over all dims, start backward search
  zobt_pkg::word_t s4_drop_seen, s4_gs, s4_cb, s4_cand;
  logic            s4_highcase;
  logic [DIMS-1:0] s4_low_any;
  zobt_pkg::word_t s4_c_q, s4_l_q, s4_rise_q, s4_gs_q, s4_cb_q, s4_qa_q;
  logic            s4_highcase_q, s4_inside_q;
  logic [DIMS-1:0] s4_low_any_q;

  assign s4_drop_seen = zobt_pkg::pref_or(s3_da_q, DIMS, 3, 5);
  assign s4_gs        = zobt_pkg::pref_or(s3_ga_q, 1, 3, 5);
  assign s4_cb        = s4_gs & ~(s4_gs >> 1);
  assign s4_highcase  = |(s4_cb & s3_high_q);
  // earlier positions with a zero key bit in a dim already below max
  assign s4_cand      = ~s3_c_q & s4_drop_seen & ~s4_gs & KM;

  for (genvar d = 0; d < DIMS; d++) begin : g_low_any
    localparam zobt_pkg::word_t DM = zobt_pkg::dim_mask(DIMS, d);
    assign s4_low_any[d] = |(s3_low_q & DM);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_c_q        <= s3_c_q;
      s4_l_q        <= s3_l_q;
      s4_rise_q     <= s3_rise_q;
      s4_gs_q       <= s4_gs;
      s4_cb_q       <= s4_cb;
      s4_highcase_q <= s4_highcase;
      s4_inside_q   <= ~|s3_fe_q;
      s4_low_any_q  <= s4_low_any;
      s4_qa_q       <= zobt_pkg::pref_or_up(s4_cand, 1, 0, 2);
    end
  end

  // stage 5: finish search (candidate closest to the exit), choose change
  // position and modified dim
  zobt_pkg::word_t s5_qs, s5_qh;
  logic [DIMS-1:0] s5_mod;
  zobt_pkg::word_t s5_c_q, s5_l_q, s5_rise_q, s5_cb_q, s5_below_q;
  logic [DIMS-1:0] s5_mod_q, s5_low_any_q;
  zobt_pkg::status_t s5_status_q;

  assign s5_qs = zobt_pkg::pref_or_up(s4_qa_q, 1, 3, 5);
  assign s5_qh = s5_qs & ~(s5_qs << 1);

  for (genvar d = 0; d < DIMS; d++) begin : g_mod
    localparam zobt_pkg::word_t DM = zobt_pkg::dim_mask(DIMS, d);
    assign s5_mod[d] = s4_highcase_q && |(s5_qh & DM);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_c_q       <= s4_c_q;
      s5_l_q       <= s4_l_q;
      s5_rise_q    <= s4_rise_q;
      s5_cb_q      <= s4_highcase_q ? s5_qh : s4_cb_q;
      s5_below_q   <= s4_highcase_q ? ~s5_qs : (s4_gs_q >> 1);
      s5_mod_q     <= s5_mod;
      s5_low_any_q <= s4_low_any_q;
      if (s4_inside_q)
        s5_status_q <= zobt_pkg::ST_INSIDE;
      else if (s4_highcase_q && ~|s4_qa_q)
        s5_status_q <= zobt_pkg::ST_NONE;
      else
        s5_status_q <= zobt_pkg::ST_NEXT;
    end
  end

  // stage 6: build next key into output register
  logic [DIMS-1:0]   s6_clr, s6_low;
  zobt_pkg::word_t   s6_res;
  zobt_pkg::word_t   next_q;
  zobt_pkg::status_t status_q;

  for (genvar d = 0; d < DIMS; d++) begin : g_dim_ctl
    localparam zobt_pkg::word_t DM = zobt_pkg::dim_mask(DIMS, d);
    assign s6_clr[d] = s5_mod_q[d] || |(s5_rise_q & DM & ~s5_below_q);
    assign s6_low[d] = s5_low_any_q[d] && !s5_mod_q[d];
  end

  for (genvar b = 0; b < W; b++) begin : g_res
    localparam int BD = (W - 1 - b) % DIMS;
    assign s6_res[b] = s6_low[BD]      ? s5_l_q[b] :
                       s5_below_q[b]   ? (s6_clr[BD] ? 1'b0 : s5_l_q[b]) :
                                         (s5_c_q[b] | s5_cb_q[b]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= s5_status_q;
      next_q   <= (s5_status_q == zobt_pkg::ST_NEXT) ? (s6_res & KM) : '0;
    end
  end

  assign res_o.valid    = v6_q;
  assign res_o.status   = status_q;
  assign res_o.next_key = next_q;

endmodule

`default_nettype wire

[verif/zorder_box_test_next_key_tb.sv]
// ----------------------------------------------------------------------------
// zorder_box_test_next_key_tb: self-checking bench for the Z-order box test
// Drives random and corner keys under several box settings, predicts the
// status and next in-box key for each request and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module zorder_box_test_next_key_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef zobt_pkg::word_t    word_t;
  typedef zobt_pkg::status_t  status_t;
  typedef zobt_pkg::cfg_idx_t cfg_idx_t;

  localparam int DIMS     = 2;
  localparam int KEY_BITS = 64;

  typedef struct packed {
    status_t status;
    word_t   next_key;
  } box_result_t;

  int err_cnt = 0;

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // Predicts the box test result for one key and keeps the pending answers
  class box_scoreboard;
    word_t       lo_corner = '0;
    word_t       hi_corner = '1;
    box_result_t pending_q[$];

    function automatic bit key_bit(word_t v, int p);
      return v[63-p];
    endfunction

    function automatic word_t bits_after(int p);
      word_t m;
      m = '0;
      for (int q = p + 1; q < 64; q++) m[63-q] = 1'b1;
      return m;
    endfunction

    function automatic box_result_t predict(word_t key_in);
      box_result_t r;
      int    flag[DIMS];
      bit    above_lo[DIMS], below_hi[DIMS];
      int    lo_step[DIMS], hi_step[DIMS], exit_step[DIMS];
      word_t dmsk[DIMS];
      word_t km, cur, lo, hi, res, aft;
      int    best, cb, dd, s;
      bit    any, found, c, l, h;
      km = (KEY_BITS >= 64) ? '1 : ~((word_t'(1) << (64 - KEY_BITS)) - 1);
      cur = key_in & km;
      lo = lo_corner & km;
      hi = hi_corner & km;
      for (int d = 0; d < DIMS; d++) begin
        flag[d] = 0; above_lo[d] = 0; below_hi[d] = 0;
        lo_step[d] = 0; hi_step[d] = 0; exit_step[d] = 0; dmsk[d] = '0;
      end
      // bit scan per dimension
      for (int p = 0; p < KEY_BITS; p++) begin
        dd = p % DIMS; s = p / DIMS;
        c = key_bit(cur, p); l = key_bit(lo, p); h = key_bit(hi, p);
        dmsk[dd][63-p] = 1'b1;
        if (flag[dd] == 0) begin
          if (!above_lo[dd]) begin
            if (!c && l) begin
              exit_step[dd] = s; flag[dd] = -1;
            end else if (c && !l) begin
              above_lo[dd] = 1; lo_step[dd] = s;
            end
          end
          if (!below_hi[dd]) begin
            if (c && !h) begin
              exit_step[dd] = s; flag[dd] = 1;
            end else if (!c && h) begin
              below_hi[dd] = 1; hi_step[dd] = s;
            end
          end
        end
      end
      // earliest exit wins, lowest dimension on a tie
      best = 0; any = 0;
      for (int d = 0; d < DIMS; d++)
        if (flag[d] != 0 && (!any || exit_step[d] < exit_step[best])) begin
          best = d; any = 1;
        end
      r.status = zobt_pkg::ST_INSIDE;
      r.next_key = '0;
      if (!any) return r;
      cb = DIMS * exit_step[best] + best;
      if (flag[best] > 0) begin
        found = 0;
        while (cb != 0 && !found) begin
          cb--;
          if (!key_bit(cur, cb)) begin
            dd = cb % DIMS; s = cb / DIMS;
            if (below_hi[dd] && hi_step[dd] <= s) begin
              above_lo[dd] = 1; lo_step[dd] = s; flag[dd] = 0; found = 1;
            end
          end
        end
        if (!found) begin
          r.status = zobt_pkg::ST_NONE;
          return r;
        end
      end
      res = cur;
      res[63-cb] = 1'b1;
      for (int d = 0; d < DIMS; d++) begin
        aft = bits_after(cb) & dmsk[d];
        if (flag[d] >= 0) begin
          if (above_lo[d] && cb >= DIMS * lo_step[d] + d) res = res & ~aft;
          else res = (res & ~aft) | (lo & aft);
        end else begin
          res = (res & ~dmsk[d]) | (lo & dmsk[d]);
        end
      end
      r.status = zobt_pkg::ST_NEXT;
      r.next_key = res & km;
      return r;
    endfunction

    function void note_request(word_t key_in);
      pending_q.insert(pending_q.size(), predict(key_in));
    endfunction

    task check_result(status_t st, word_t nk);
      box_result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", word_t'(st), '0);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) report_mismatch("status", word_t'(st), word_t'(e.status));
      if (nk !== e.next_key) report_mismatch("next_key", nk, e.next_key);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  zobt_key_if key_ch();
  zobt_res_if res_ch();
  zobt_cfg_if cfg_ch();

  zorder_box_test_next_key #(.DIMS(DIMS), .KEY_BITS(KEY_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i (key_ch.sink),
    .res_o (res_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  box_scoreboard sb = new();
  bit            hold_results = 1'b0;
  bit            drain_waits = 1'b0;

  initial begin
    key_ch.valid = 1'b0;
    key_ch.current_key = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = zobt_pkg::REG_BOX_MIN;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // accept check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && key_ch.valid && key_ch.ready) sb.note_request(key_ch.current_key);
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.status, res_ch.next_key);
  end

  // result side: random stalls, long hold when asked
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        res_ch.ready <= 1'b0;
      end else begin
        gap = drain_waits ? $urandom_range(0, 15) : 0;
        if (gap != 0 && $urandom_range(0, 3) != 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // driven at the falling edge with blocking writes, so back-to-back calls
  // may drop and raise valid within one time step
  task automatic send_key(input word_t k, input int gap);
    repeat (gap) @(negedge clk_i);
    key_ch.valid = 1'b1;
    key_ch.current_key = k;
    @(posedge clk_i);
    while (!key_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    key_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    sb.lo_corner = (idx == zobt_pkg::REG_BOX_MIN) ? val : sb.lo_corner;
    sb.hi_corner = (idx == zobt_pkg::REG_BOX_MAX) ? val : sb.hi_corner;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // key near the box: a corner, a corner blend or a random word, with up to three bits flipped
  function automatic word_t near_key();
    word_t k;
    case ($urandom_range(0, 3))
      0: k = sb.lo_corner;
      1: k = sb.hi_corner;
      2: k = sb.lo_corner | (rand_word() & sb.hi_corner);
      default: k = rand_word();
    endcase
    repeat ($urandom_range(0, 3)) k[$urandom_range(0, 63)] ^= 1'b1;
    return k;
  endfunction

  task automatic set_box(input word_t lo, input word_t hi);
    write_reg(zobt_pkg::REG_BOX_MIN, lo);
    write_reg(zobt_pkg::REG_BOX_MAX, hi);
  endtask

  // random box with min below max in both dimensions often enough
  task automatic random_box();
    word_t a, b, m0;
    a = rand_word();
    b = rand_word();
    m0 = zobt_pkg::dim_mask(DIMS, 0);
    if ($urandom_range(0, 3) != 0) begin
      if ((a & m0) > (b & m0)) begin
        a = (a & ~m0) | (b & m0);
        b = (b & ~m0) | (rand_word() & m0);
      end
      set_box(a, a | b);
    end else begin
      set_box(a, b);
    end
  endtask

  initial begin
    word_t dir_keys[$];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes with reset box, then a small box
    dir_keys = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h1, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555};
    foreach (dir_keys[i]) send_key(dir_keys[i], 0);
    wait_drained();
    set_box(64'h0000_0000_0000_00F0, 64'h0000_0000_0000_0F3C);
    dir_keys = '{64'h0, 64'h0000_0000_0000_00F0, 64'h0000_0000_0000_0F3C, '1,
                 64'h0000_0000_0000_0100, 64'h0000_0000_0000_00F1, 64'h0000_0000_0000_0F3D,
                 64'h0000_0000_0000_0800, 64'h0000_0000_0000_0002, 64'h0000_0000_0000_0400};
    foreach (dir_keys[i]) send_key(dir_keys[i], 0);
    wait_drained();
    // max corner all ones, min at top, and inverted box
    set_box('1, '1);
    send_key('1, 0); send_key(64'h0, 0); send_key(64'hFFFF_FFFF_FFFF_FFFE, 0);
    wait_drained();
    set_box(64'hC000_0000_0000_0000, 64'h3000_0000_0000_0000);
    send_key(64'h0, 0); send_key(64'hF000_0000_0000_0000, 0); send_key('1, 0);
    wait_drained();

    // back pressure: hold results while keys pile up
    drain_waits = 1'b1;
    random_box();
    fork
      begin
        hold_results = 1'b1;
        repeat (60) @(negedge clk_i);
        hold_results = 1'b0;
      end
      repeat (30) send_key(near_key(), 0);
    join
    wait_drained();

    // random phases with a new box each
    for (int ph = 0; ph < 24; ph++) begin
      if (ph % 8 == 7) set_box('0, '1);
      else random_box();
      repeat (80) begin
        if ($urandom_range(0, 4) == 0) send_key(rand_word(), 0);
        else send_key(near_key(), ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0);
      end
      wait_drained();
    end

    wait_drained();
    if (err_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/zobt_pkg.sv
sv/zobt_if.sv
sv/zorder_box_test_next_key.sv
verif/zorder_box_test_next_key_tb.sv
